/* design/lstp_pkg.sv */
`default_nettype none

package lstp_pkg;

    // width of the point index and of the stored point count (8 to 16)
    localparam int IDX_BITS = 16;

    localparam int BYTE_W  = 8;
    localparam int TOK_W   = 16;
    localparam int VAL_W   = 32;
    localparam int OFF_W   = 8;
    localparam int PIDX_W  = 16;

    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CH_SEP = 8'h20;

    localparam logic [TOK_W-1:0]  TOKEN_MAX  = 16'hFFFF;
    localparam logic [OFF_W-1:0]  OFF_RESET  = 8'd23;

    // token end seen by the point unit
    typedef struct packed {
        logic              tok_end;
        logic [TOK_W-1:0]  count;
        logic [VAL_W-1:0]  value;
    } t_tok_evt;

endpackage

`default_nettype wire

/* design/lstp_byte_if.sv */
`default_nettype none

interface lstp_byte_if;
    logic                        valid;
    logic                        ready;
    logic [lstp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/lstp_point_if.sv */
`default_nettype none

interface lstp_point_if;
    logic                               valid;
    logic                               ready;
    logic        [lstp_pkg::PIDX_W-1:0] point_index;
    logic signed [lstp_pkg::VAL_W-1:0]  point_angle;
    logic        [lstp_pkg::VAL_W-1:0]  distance;
    logic                               last_point;

    modport source (output valid, output point_index, output point_angle,
                    output distance, output last_point, input ready);
    modport sink   (input valid, input point_index, input point_angle,
                    input distance, input last_point, output ready);
endinterface

`default_nettype wire

/* design/lstp_cfg_if.sv */
`default_nettype none

interface lstp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lstp_pkg::OFF_W-1:0] angle_field_offset;

    modport source (output valid, output angle_field_offset, input ready);
    modport sink   (input valid, input angle_field_offset, output ready);
endinterface

`default_nettype wire

/* design/lstp_tokenizer.sv */
`default_nettype none

module lstp_tokenizer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [lstp_pkg::BYTE_W-1:0] i_byte,
    output lstp_pkg::t_tok_evt               o_evt
);
    import lstp_pkg::*;

    logic              r_in_frame, n_in_frame;
    logic [TOK_W-1:0]  r_count,    n_count;
    logic [VAL_W-1:0]  r_hex,      n_hex;
    logic              r_stopped,  n_stopped;
    logic              dig_ok;
    logic [3:0]        dig_val;

    // ascii hex digit decode, both cases
    always_comb begin
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            dig_ok  = 1'b1;
            dig_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            dig_ok  = 1'b1;
            dig_val = 4'(i_byte - 8'h37);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            dig_ok  = 1'b1;
            dig_val = 4'(i_byte - 8'h57);
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_hex      = r_hex;
        n_stopped  = r_stopped;
        o_evt      = '0;
        o_evt.count = r_count;
        o_evt.value = r_hex;
        if (i_fire) begin
            if (i_byte == CH_STX) begin
                n_in_frame = 1'b1;
                n_count    = '0;
                n_hex      = '0;
                n_stopped  = 1'b0;
            end else if (r_in_frame) begin
                if (i_byte == CH_SEP || i_byte == CH_ETX) begin
                    // a token ending at the saturated count is dropped
                    if (r_count != TOKEN_MAX) begin
                        o_evt.tok_end = 1'b1;
                        n_count       = r_count + 1'b1;
                    end
                    n_hex     = '0;
                    n_stopped = 1'b0;
                    if (i_byte == CH_ETX) begin
                        n_in_frame = 1'b0;
                    end
                end else if (!r_stopped) begin
                    if (dig_ok) begin
                        n_hex = {r_hex[VAL_W-5:0], dig_val};
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_hex      <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_hex      <= n_hex;
            r_stopped  <= n_stopped;
        end
    end

endmodule

`default_nettype wire

/* design/lstp_point_unit.sv */
`default_nettype none

module lstp_point_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lstp_pkg::t_tok_evt         i_evt,
    input  wire logic [lstp_pkg::OFF_W-1:0] i_offset,
    output logic                            o_adv,
    lstp_point_if.source                    o_pt
);
    import lstp_pkg::*;

    logic [VAL_W-1:0]     r_step,    n_step;
    logic [IDX_BITS-1:0]  r_expect,  n_expect;
    logic [VAL_W-1:0]     r_run,     n_run;
    logic                 r_out_vld, n_out_vld;
    logic [PIDX_W-1:0]    r_idx;
    logic [VAL_W-1:0]     r_ang;
    logic [VAL_W-1:0]     r_dist;
    logic                 r_last;
    logic                 emit;

    logic [TOK_W:0]       t17;
    logic [TOK_W:0]       off0, off1, off2, off3;
    logic [TOK_W-1:0]     k;
    logic [TOK_W:0]       k17;
    logic [TOK_W:0]       exp17;

    assign o_adv = !r_out_vld || o_pt.ready;

    assign t17   = {1'b0, i_evt.count};
    assign off0  = (TOK_W+1)'(i_offset);
    assign off1  = off0 + 1'b1;
    assign off2  = off0 + 2'd2;
    assign off3  = off0 + 2'd3;
    assign k     = i_evt.count - off3[TOK_W-1:0];
    assign k17   = {1'b0, k};
    assign exp17 = (TOK_W+1)'(r_expect);

    always_comb begin
        n_step    = r_step;
        n_expect  = r_expect;
        n_run     = r_run;
        emit      = 1'b0;
        if (i_evt.tok_end) begin
            if (t17 == off0) begin
                n_run   = i_evt.value;
            end else if (t17 == off1) begin
                n_step = i_evt.value;
            end else if (t17 == off2) begin
                n_expect = i_evt.value[IDX_BITS-1:0];
            end else if (t17 >= off3 && k17 < exp17) begin
                emit  = 1'b1;
                n_run = r_run + r_step;
            end
        end
        if (emit) begin
            n_out_vld = 1'b1;
        end else if (o_pt.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_expect  <= '0;
            r_run     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_expect  <= n_expect;
            r_run     <= n_run;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_idx  <= PIDX_W'(k[IDX_BITS-1:0]);
            r_ang  <= r_run;
            r_dist <= i_evt.value;
            r_last <= (k17 + 1'b1) == exp17;
        end
    end

    assign o_pt.valid       = r_out_vld;
    assign o_pt.point_index = r_idx;
    assign o_pt.point_angle = r_ang;
    assign o_pt.distance    = r_dist;
    assign o_pt.last_point  = r_last;

endmodule

`default_nettype wire

/* design/lidar_scan_telegram_parser_unit.sv */
`default_nettype none

// scan telegram parser: takes one ascii character per cycle into the input
// register; the tokenizer is combinational and the point unit registers a point
// when the separator that ends its distance token leaves the input register.
// sustained rate is one character per clock; the only stall comes from a held
// point word that the sink has not taken. running angle is kept by one 32-bit
// add per point. configuration is taken at any time, always ready.
module lidar_scan_telegram_parser_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lstp_byte_if.sink    i_rx,
    lstp_cfg_if.sink     i_cfg,
    lstp_point_if.source o_pt
);
    import lstp_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic [OFF_W-1:0]  r_offset;
    logic              adv;
    logic              fire;
    t_tok_evt          evt;

    assign fire       = r_in_vld && adv;
    assign i_rx.ready = !r_in_vld || adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_offset <= OFF_RESET;
        end else begin
            if (i_rx.ready) begin
                r_in_vld <= i_rx.valid;
            end
            if (i_cfg.valid) begin
                r_offset <= i_cfg.angle_field_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    lstp_tokenizer u_tok (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    lstp_point_unit u_pt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .i_offset (r_offset),
        .o_adv    (adv),
        .o_pt     (o_pt)
    );

endmodule

`default_nettype wire
